### rtl/core/thermostat_with_serial_commands_macros.svh
// ----------------------------------------------------------------------------
// Thermostat assertion macros
// Concurrent assertion helpers shared by the thermostat modules. Simulation
// builds get the checks; synthesis builds get empty bodies.
// ----------------------------------------------------------------------------
`ifndef THERMOSTAT_WITH_SERIAL_COMMANDS_MACROS_SVH
`define THERMOSTAT_WITH_SERIAL_COMMANDS_MACROS_SVH

`ifndef SYNTHESIS
// Checks that an expression holds at every clock edge out of reset.
`define TSC_ASSERT(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("thermostat assertion failed");
// Checks that a condition is followed in the next cycle by a consequence.
`define TSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("thermostat sequence assertion failed");
`else
`define TSC_ASSERT(label, expr)
`define TSC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/core/tsc_pkg.sv
// ----------------------------------------------------------------------------
// Thermostat package
// Codes, constants, types and helper functions shared by the thermostat.
// ----------------------------------------------------------------------------
package tsc_pkg;

    // Default converter resolution.
    localparam int ADC_BITS_DEF = 12;

    // Word kinds on the input channel.
    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;

    // Operating modes.
    localparam logic [1:0] MODE_AUTO = 2'd0;
    localparam logic [1:0] MODE_ON   = 2'd1;
    localparam logic [1:0] MODE_OFF  = 2'd2;

    // Serial command characters.
    localparam logic [7:0] CHR_START = 8'h21;  // '!'
    localparam logic [7:0] CHR_MODE  = 8'h42;  // 'B'
    localparam logic [7:0] CHR_TEMP  = 8'h54;  // 'T'
    localparam logic [7:0] CHR_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CHR_AUTO  = 8'h31;  // '1'
    localparam logic [7:0] CHR_ON    = 8'h32;  // '2'

    localparam logic signed [15:0] SET_POINT_RST = 16'sd70;

    // Sensor transfer: C = (code * VREF_MV - OFFSET_MV * 2^N) / (10 * 2^N).
    // Both constants divide by ten, leaving a pure power-of-two divide.
    localparam int VREF_MV    = 3300;
    localparam int OFFSET_MV  = 500;
    localparam int SCALE_DIV  = VREF_MV / 10;
    localparam int OFFSET_DIV = OFFSET_MV / 10;

    // Division by five as a multiply by 6554 / 2^15, exact for 0..2511.
    localparam int RECIP_DIV5  = 6554;
    localparam int RECIP_SHIFT = 15;

    localparam logic signed [11:0] F_OFFSET = 12'sd32;
    localparam logic signed [11:0] F_MAX    = 12'sd100;

    typedef enum logic [2:0] {
        PS_WAIT,
        PS_CMD,
        PS_MODE,
        PS_DIG1,
        PS_DIG2,
        PS_DIG3
    } parse_state_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_EXEC,
        CS_SCALE,
        CS_RECIP,
        CS_CLAMP,
        CS_PUSH
    } ctrl_state_t;

    typedef struct packed {
        logic load_item;
        logic parse_en;
        logic tick_en;
        logic mul_en;
        logic scale_en;
        logic recip_en;
        logic clamp_en;
        logic push;
    } tsc_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
    } tsc_status_t;

    function automatic logic [2:0] mode_to_leds(input logic [1:0] mode);
        logic [2:0] leds;
        case (mode)
            MODE_AUTO: leds = 3'b001;
            MODE_ON:   leds = 3'b010;
            default:   leds = 3'b100;
        endcase
        return leds;
    endfunction

endpackage

### rtl/core/tsc_ctrl.sv
// ----------------------------------------------------------------------------
// Thermostat controller
// Sequences each word through the datapath and owns the result valid flag.
// ----------------------------------------------------------------------------
`include "thermostat_with_serial_commands_macros.svh"

module tsc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  tsc_pkg::tsc_status_t status,
    output tsc_pkg::tsc_cmd_t    cmd
);

    tsc_pkg::ctrl_state_t state_reg, state_next;
    logic                 m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tsc_pkg::CS_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            tsc_pkg::CS_IDLE: begin
                // No word is taken while reset is held.
                s_ready = aresetn;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = tsc_pkg::CS_EXEC;
                end
            end
            tsc_pkg::CS_EXEC: begin
                state_next = tsc_pkg::CS_PUSH;
                case (status.kind)
                    tsc_pkg::KIND_BYTE:   cmd.parse_en = 1'b1;
                    tsc_pkg::KIND_TICK:   cmd.tick_en  = 1'b1;
                    tsc_pkg::KIND_SAMPLE: begin
                        cmd.mul_en = 1'b1;
                        state_next = tsc_pkg::CS_SCALE;
                    end
                    default: ;
                endcase
            end
            tsc_pkg::CS_SCALE: begin
                cmd.scale_en = 1'b1;
                state_next   = tsc_pkg::CS_RECIP;
            end
            tsc_pkg::CS_RECIP: begin
                cmd.recip_en = 1'b1;
                state_next   = tsc_pkg::CS_CLAMP;
            end
            tsc_pkg::CS_CLAMP: begin
                cmd.clamp_en = 1'b1;
                state_next   = tsc_pkg::CS_PUSH;
            end
            tsc_pkg::CS_PUSH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.push   = 1'b1;
                    state_next = tsc_pkg::CS_IDLE;
                end
            end
            default: state_next = tsc_pkg::CS_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.push) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

    `TSC_ASSERT_NEXT(a_accept_to_exec, s_valid && s_ready, state_reg == tsc_pkg::CS_EXEC)
    `TSC_ASSERT_NEXT(a_clamp_to_push, state_reg == tsc_pkg::CS_CLAMP, state_reg == tsc_pkg::CS_PUSH)
    `TSC_ASSERT_NEXT(a_push_sets_valid, cmd.push, m_valid_reg)

endmodule

### rtl/core/tsc_datapath.sv
// ----------------------------------------------------------------------------
// Thermostat datapath
// Command parser, sample conversion pipeline, load control and result word.
// ----------------------------------------------------------------------------
`include "thermostat_with_serial_commands_macros.svh"

module tsc_datapath #(
    parameter int ADC_BITS = tsc_pkg::ADC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tsc_pkg::tsc_cmd_t     cmd,
    output tsc_pkg::tsc_status_t  status,
    input  logic [1:0]            s_kind,
    input  logic [7:0]            s_rx_byte,
    input  logic [ADC_BITS-1:0]   s_sample,
    output logic                  m_load_on,
    output logic [1:0]            m_mode,
    output logic [2:0]            m_mode_leds,
    output logic [6:0]            m_temperature_f,
    output logic signed [15:0]    m_set_point,
    output logic                  m_report_valid
);

    localparam int PW = ADC_BITS + 9;   // code times the scale constant
    localparam int MW = ADC_BITS + 13;  // signed numerator
    localparam logic [MW-1:0] OFFSET_Q = MW'(tsc_pkg::OFFSET_DIV) << ADC_BITS;
    localparam logic [MW-1:0] ROUND_Q  = {{(MW-ADC_BITS){1'b0}}, {ADC_BITS{1'b1}}};
    localparam int RW = 25;

    // Captured word.
    logic [1:0]          kind_reg;
    logic [7:0]          byte_reg;
    logic [ADC_BITS-1:0] sample_reg;

    // Conversion pipeline.
    logic [PW-1:0]       prod_reg;
    logic [11:0]         abs_reg;
    logic                neg_reg;
    logic [RW-1:0]       recip_reg;

    // Architectural state.
    tsc_pkg::parse_state_t parse_state_reg, parse_state_next;
    logic [1:0]            mode_reg, mode_next;
    logic signed [15:0]    set_point_reg, set_point_next;
    logic signed [15:0]    digit_accum_reg, digit_accum_next;
    logic [6:0]            temp_reg, temp_next;
    logic                  load_reg, load_next;

    // Result word.
    logic                  m_load_on_reg;
    logic [1:0]            m_mode_reg;
    logic [2:0]            m_mode_leds_reg;
    logic [6:0]            m_temperature_f_reg;
    logic signed [15:0]    m_set_point_reg;
    logic                  m_report_valid_reg;

    logic [MW-1:0]         m_val, m_adj;
    logic signed [MW-1:0]  c_wide;
    logic signed [12:0]    c_ext, c9;
    logic [11:0]           abs_val;
    logic [9:0]            quot;
    logic signed [11:0]    f_val;
    logic signed [15:0]    digit;
    logic signed [15:0]    temp_s;

    assign status.kind = kind_reg;

    // Sample conversion arithmetic, one step per pipeline register.
    always_comb begin
        m_val   = MW'(prod_reg) - OFFSET_Q;
        m_adj   = m_val[MW-1] ? (m_val + ROUND_Q) : m_val;
        c_wide  = $signed(m_adj) >>> ADC_BITS;
        c_ext   = 13'(c_wide);
        c9      = (c_ext <<< 3) + c_ext;
        abs_val = c9[12] ? 12'(-c9) : 12'(c9);
        quot    = recip_reg[tsc_pkg::RECIP_SHIFT +: 10];
        f_val   = neg_reg ? (tsc_pkg::F_OFFSET - $signed({2'b00, quot}))
                          : ($signed({2'b00, quot}) + tsc_pkg::F_OFFSET);
    end

    always_comb begin
        parse_state_next = parse_state_reg;
        mode_next        = mode_reg;
        set_point_next   = set_point_reg;
        digit_accum_next = digit_accum_reg;
        temp_next        = temp_reg;
        load_next        = load_reg;
        digit            = $signed(16'(byte_reg)) - $signed(16'(tsc_pkg::CHR_ZERO));
        temp_s           = $signed({9'd0, temp_reg});

        if (cmd.parse_en) begin
            case (parse_state_reg)
                tsc_pkg::PS_WAIT: begin
                    if (byte_reg == tsc_pkg::CHR_START) begin
                        parse_state_next = tsc_pkg::PS_CMD;
                    end
                end
                tsc_pkg::PS_CMD: begin
                    if (byte_reg == tsc_pkg::CHR_MODE) begin
                        parse_state_next = tsc_pkg::PS_MODE;
                    end else if (byte_reg == tsc_pkg::CHR_TEMP) begin
                        parse_state_next = tsc_pkg::PS_DIG1;
                    end else begin
                        parse_state_next = tsc_pkg::PS_WAIT;
                    end
                end
                tsc_pkg::PS_MODE: begin
                    if (byte_reg == tsc_pkg::CHR_AUTO) begin
                        mode_next = tsc_pkg::MODE_AUTO;
                    end else if (byte_reg == tsc_pkg::CHR_ON) begin
                        mode_next = tsc_pkg::MODE_ON;
                    end else begin
                        mode_next = tsc_pkg::MODE_OFF;
                    end
                    parse_state_next = tsc_pkg::PS_WAIT;
                end
                tsc_pkg::PS_DIG1: begin
                    digit_accum_next = 16'(digit * 16'sd100);
                    parse_state_next = tsc_pkg::PS_DIG2;
                end
                tsc_pkg::PS_DIG2: begin
                    digit_accum_next = digit_accum_reg + 16'(digit * 16'sd10);
                    parse_state_next = tsc_pkg::PS_DIG3;
                end
                tsc_pkg::PS_DIG3: begin
                    set_point_next   = digit_accum_reg + digit;
                    digit_accum_next = '0;
                    parse_state_next = tsc_pkg::PS_WAIT;
                end
                default: parse_state_next = tsc_pkg::PS_WAIT;
            endcase
        end

        if (cmd.tick_en) begin
            case (mode_reg)
                tsc_pkg::MODE_ON:  load_next = 1'b1;
                tsc_pkg::MODE_OFF: load_next = 1'b0;
                default: begin
                    if (temp_s > set_point_reg) begin
                        load_next = 1'b1;
                    end else if (temp_s < set_point_reg) begin
                        load_next = 1'b0;
                    end
                end
            endcase
        end

        if (cmd.clamp_en) begin
            if (f_val < 12'sd0) begin
                temp_next = '0;
            end else if (f_val > tsc_pkg::F_MAX) begin
                temp_next = 7'(tsc_pkg::F_MAX);
            end else begin
                temp_next = f_val[6:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parse_state_reg <= tsc_pkg::PS_WAIT;
            mode_reg        <= tsc_pkg::MODE_AUTO;
            set_point_reg   <= tsc_pkg::SET_POINT_RST;
            digit_accum_reg <= '0;
            temp_reg        <= '0;
            load_reg        <= 1'b0;
        end else begin
            parse_state_reg <= parse_state_next;
            mode_reg        <= mode_next;
            set_point_reg   <= set_point_next;
            digit_accum_reg <= digit_accum_next;
            temp_reg        <= temp_next;
            load_reg        <= load_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            kind_reg   <= s_kind;
            byte_reg   <= s_rx_byte;
            sample_reg <= s_sample;
        end
        if (cmd.mul_en) begin
            prod_reg <= PW'(sample_reg) * PW'(tsc_pkg::SCALE_DIV);
        end
        if (cmd.scale_en) begin
            abs_reg <= abs_val;
            neg_reg <= c9[12];
        end
        if (cmd.recip_en) begin
            recip_reg <= RW'(abs_reg) * RW'(tsc_pkg::RECIP_DIV5);
        end
        if (cmd.push) begin
            m_load_on_reg       <= load_reg;
            m_mode_reg          <= mode_reg;
            m_mode_leds_reg     <= tsc_pkg::mode_to_leds(mode_reg);
            m_temperature_f_reg <= temp_reg;
            m_set_point_reg     <= set_point_reg;
            m_report_valid_reg  <= (kind_reg == tsc_pkg::KIND_SAMPLE);
        end
    end

    assign m_load_on       = m_load_on_reg;
    assign m_mode          = m_mode_reg;
    assign m_mode_leds     = m_mode_leds_reg;
    assign m_temperature_f = m_temperature_f_reg;
    assign m_set_point     = m_set_point_reg;
    assign m_report_valid  = m_report_valid_reg;

    `TSC_ASSERT(a_temp_in_range, temp_reg <= 7'(tsc_pkg::F_MAX))
    `TSC_ASSERT(a_mode_legal, mode_reg == tsc_pkg::MODE_AUTO || mode_reg == tsc_pkg::MODE_ON || mode_reg == tsc_pkg::MODE_OFF)
    `TSC_ASSERT(a_accum_clear_outside_digits, !(parse_state_reg == tsc_pkg::PS_WAIT || parse_state_reg == tsc_pkg::PS_CMD || parse_state_reg == tsc_pkg::PS_MODE) || digit_accum_reg == 16'sd0)

endmodule

### rtl/core/thermostat_with_serial_commands.sv
// ----------------------------------------------------------------------------
// Thermostat with serial commands
// Bang-bang load controller with a serial command parser and sensor
// conversion to degrees Fahrenheit.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Word contents
//  s_*       in         s_valid/s_ready    kind, rx_byte, sample
//  m_*       out        m_valid/m_ready    load, mode, LEDs, temperature,
//                                          set point, report flag
//
// A serial byte, a control tick or a word of the spare kind passes through the
// execute and push states to the result register; a sensor sample also goes
// through the four-step conversion pipeline (scale multiply, offset and divide
// by 2^ADC_BITS, reciprocal multiply for the divide by five, clamp).
// The block takes the next word in its idle state, after the push.
// One word is in work at a time. The result register frees the input side:
// once a result is loaded the block takes the next word even if the result
// has not been read yet. A stalled m_ready holds the controller at the
// result stage until the register can be reloaded.
// Reset is synchronous and active low; s_ready stays low while it is held
// and rises in the first cycle after it.
//
module thermostat_with_serial_commands #(
    parameter int ADC_BITS = tsc_pkg::ADC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_kind,
    input  logic [7:0]            s_rx_byte,
    input  logic [ADC_BITS-1:0]   s_sample,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_load_on,
    output logic [1:0]            m_mode,
    output logic [2:0]            m_mode_leds,
    output logic [6:0]            m_temperature_f,
    output logic signed [15:0]    m_set_point,
    output logic                  m_report_valid
);

    // Command and status buses between the sequencer and the datapath.
    tsc_pkg::tsc_cmd_t    cmd;
    tsc_pkg::tsc_status_t status;

    // The controller walks each word through its steps and owns m_valid.
    tsc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath holds the parser, mode, set point, temperature and load
    // state, plus the conversion pipeline and the result register.
    tsc_datapath #(
        .ADC_BITS (ADC_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_kind          (s_kind),
        .s_rx_byte       (s_rx_byte),
        .s_sample        (s_sample),
        .m_load_on       (m_load_on),
        .m_mode          (m_mode),
        .m_mode_leds     (m_mode_leds),
        .m_temperature_f (m_temperature_f),
        .m_set_point     (m_set_point),
        .m_report_valid  (m_report_valid)
    );

endmodule
